### hw/rtl/ctl_pkg.sv
// Package: shared types, constants and keyword table for the C token lexer.
package ctl_pkg;

  localparam int POS_BITS_DEF     = 32;
  localparam int COL_BITS_DEF     = 16;
  localparam int NUM_KEYWORDS_DEF = 32;
  localparam int KW_TABLE_SIZE    = 32;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [3:0]  TAB_RESET = 4'd4;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_IDENT     = 3'd1,
    MODE_NUMBER    = 3'd2,
    MODE_STRING    = 3'd3,
    MODE_CHAR_OPEN = 3'd4,
    MODE_CHAR_BODY = 3'd5
  } lex_mode_t;

  typedef enum logic [4:0] {
    TK_IDENT      = 5'd0,
    TK_KEYWORD    = 5'd1,
    TK_NUMBER     = 5'd2,
    TK_STRING     = 5'd3,
    TK_CHAR       = 5'd4,
    TK_LPAREN     = 5'd5,
    TK_RPAREN     = 5'd6,
    TK_LBRACE     = 5'd7,
    TK_RBRACE     = 5'd8,
    TK_ASSIGN     = 5'd9,
    TK_STAR       = 5'd10,
    TK_SEMI       = 5'd11,
    TK_EOF        = 5'd12,
    TK_ERR_CHAR   = 5'd13,
    TK_ERR_STRING = 5'd14,
    TK_ERR_CLIT   = 5'd15,
    TK_ERR_BIG    = 5'd16
  } token_kind_t;

  function automatic logic [63:0] kw_hash(input int i);
    logic [63:0] h;
    case (i)
      0:  h = 64'd417800907370030071;
      1:  h = 64'd617372513566700692;
      2:  h = 64'd628023482707099174;
      3:  h = 64'd1390995973168426656;
      4:  h = 64'd3143511548502526014;
      5:  h = 64'd3563412735833858527;
      6:  h = 64'd5416238596490301492;
      7:  h = 64'd5788750116080139093;
      8:  h = 64'd6757501175350325814;
      9:  h = 64'd7334518323283222324;
      10: h = 64'd9163537027783908656;
      11: h = 64'd9964885110000857501;
      12: h = 64'd10474992716130377088;
      13: h = 64'd10644074229358120504;
      14: h = 64'd10769778583944859405;
      15: h = 64'd11331286950270920518;
      16: h = 64'd11532138274943533413;
      17: h = 64'd11567507311810436776;
      18: h = 64'd11936925801837197745;
      19: h = 64'd13068990443679199185;
      20: h = 64'd13236544317732455142;
      21: h = 64'd14058172984575203104;
      22: h = 64'd14210125031242066299;
      23: h = 64'd14251563519059995999;
      24: h = 64'd14837330719131395891;
      25: h = 64'd14882043299657492846;
      26: h = 64'd15186091406668687012;
      27: h = 64'd15902905282948881040;
      28: h = 64'd16509985740318510052;
      29: h = 64'd16982411286042166782;
      30: h = 64'd17483980429552467645;
      31: h = 64'd17767075776831802709;
      default: h = '0;
    endcase
    return h;
  endfunction

  function automatic logic [3:0] kw_len(input int i);
    logic [3:0] l;
    case (i)
      0, 7, 11, 17, 18, 21, 22, 23: l = 4'd6;
      1, 2:                          l = 4'd2;
      3, 14, 20, 26:                 l = 4'd8;
      4, 27:                         l = 4'd3;
      6, 9, 13, 16, 25, 31:          l = 4'd5;
      28, 29:                        l = 4'd7;
      5, 8, 10, 12, 15, 19, 24, 30:  l = 4'd4;
      default:                       l = 4'd0;
    endcase
    return l;
  endfunction

  // FNV-1a-64 step: prime is 2^40 + 2^8 + 0xb3, so the multiply is shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] c);
    logic [63:0] x;
    x = h ^ {56'd0, c};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

### hw/rtl/c_token_lexer.sv
// Top level: streaming C tokenizer, one character item per cycle while in_ready is high.
//
//  channel   signals                       direction  payload
//  in        in_valid / in_ready           sink       ch, is_end
//  out       out_valid / out_ready         source     token fields, last
//  cfg       cfg_we / cfg_wdata            sink       tab_width
//
// One item enters per cycle; its work is done in the cycle it is accepted and
// its results (up to two) go into a two-entry output queue, visible at the
// ports the cycle after. An item is taken only when the queue has room for two
// results after this cycle's pop: empty, or one result that leaves now. An
// item giving two results fills the queue, so the next item waits while it is
// full even with out_ready high; with out_ready low any queued result stalls input.
// Reset clears the lexer state and the queue; tab width returns to 4.
module c_token_lexer import ctl_pkg::*; #(
  parameter int POS_BITS     = POS_BITS_DEF,
  parameter int COL_BITS     = COL_BITS_DEF,
  parameter int NUM_KEYWORDS = NUM_KEYWORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          ch,
  input  logic                is_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          token_kind,
  output logic [4:0]          keyword_index,
  output logic [POS_BITS-1:0] token_line,
  output logic [COL_BITS-1:0] token_col,
  output logic [POS_BITS-1:0] token_start,
  output logic [POS_BITS-1:0] token_length,
  output logic                last,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata
);

  localparam logic [POS_BITS-1:0] PMAX = '1;
  localparam logic [COL_BITS-1:0] CMAX = '1;

  typedef struct packed {
    logic [4:0]          kind;
    logic [4:0]          kw;
    logic [POS_BITS-1:0] line;
    logic [COL_BITS-1:0] col;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS-1:0] len;
    logic                lst;
  } res_t;

  logic [3:0]          tab_width;
  lex_mode_t           mode, mode_next;
  logic [63:0]         hash, hash_next;
  logic [POS_BITS-1:0] run_len, run_len_next;
  logic [POS_BITS-1:0] st_off, st_off_next, st_line, st_line_next;
  logic [COL_BITS-1:0] st_col, st_col_next;
  logic [POS_BITS-1:0] cur_off, cur_off_next, cur_line, cur_line_next;
  logic [COL_BITS-1:0] cur_col, cur_col_next;

  res_t       q0, q1, r0, r1;
  logic [1:0] cnt;
  logic [1:0] nres;

  logic kw_hit;
  logic [4:0] kw_idx;

  ctl_kw_match #(.POS_BITS(POS_BITS), .NUM_KEYWORDS(NUM_KEYWORDS)) u_kw (
    .hash(hash), .length(run_len), .hit(kw_hit), .index(kw_idx)
  );

  logic accept, pop;
  assign in_ready  = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = cnt != 2'd0;
  assign pop       = out_valid && out_ready;

  assign token_kind    = q0.kind;
  assign keyword_index = q0.kw;
  assign token_line    = q0.line;
  assign token_col     = q0.col;
  assign token_start   = q0.start;
  assign token_length  = q0.len;
  assign last          = q0.lst;

  always_comb begin
    logic alpha, digit, ws, is_punct, restart, at_eof;
    logic [4:0] pk;
    logic [POS_BITS-1:0] rl_inc;
    logic [COL_BITS:0] csum;
    res_t fin, tk;

    alpha = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
    digit = ch >= 8'h30 && ch <= 8'h39;
    ws    = ch == 8'h20 || ch == 8'h0a || ch == 8'h09;
    is_punct = 1'b1;
    csum = '0;
    case (ch)
      8'h28:   pk = TK_LPAREN;
      8'h29:   pk = TK_RPAREN;
      8'h7b:   pk = TK_LBRACE;
      8'h7d:   pk = TK_RBRACE;
      8'h3d:   pk = TK_ASSIGN;
      8'h2a:   pk = TK_STAR;
      8'h3b:   pk = TK_SEMI;
      default: begin
        pk = TK_ERR_CHAR;
        is_punct = 1'b0;
      end
    endcase
    rl_inc = (run_len == PMAX) ? PMAX : run_len + 1'b1;

    mode_next = mode; hash_next = hash; run_len_next = run_len;
    st_off_next = st_off; st_line_next = st_line; st_col_next = st_col;
    cur_off_next = cur_off; cur_line_next = cur_line; cur_col_next = cur_col;
    nres = 2'd0; r0 = '0; r1 = '0;

    fin.kind = TK_IDENT; fin.kw = '0; fin.line = st_line; fin.col = st_col;
    fin.start = st_off; fin.len = run_len; fin.lst = 1'b0;
    tk.kind = pk; tk.kw = '0; tk.line = cur_line; tk.col = cur_col;
    tk.start = cur_off; tk.len = POS_BITS'(1); tk.lst = 1'b0;

    restart = 1'b0;
    at_eof  = 1'b0;
    if (is_end) begin
      at_eof = 1'b1;
      case (mode)
        MODE_IDENT: begin
          nres = 2'd1;
          fin.kind = kw_hit ? TK_KEYWORD : TK_IDENT;
          fin.kw = kw_hit ? kw_idx : 5'd0;
        end
        MODE_NUMBER: begin nres = 2'd1; fin.kind = TK_NUMBER; end
        MODE_STRING: begin nres = 2'd1; fin.kind = TK_ERR_STRING; end
        MODE_CHAR_OPEN, MODE_CHAR_BODY: begin nres = 2'd1; fin.kind = TK_ERR_CLIT; end
        default: nres = 2'd0;
      endcase
      mode_next = MODE_IDLE;
    end else begin
      case (mode)
        MODE_IDENT: begin
          if (!(alpha || digit)) begin
            nres = 2'd1;
            fin.kind = kw_hit ? TK_KEYWORD : TK_IDENT;
            fin.kw = kw_hit ? kw_idx : 5'd0;
            restart = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (!digit) begin nres = 2'd1; fin.kind = TK_NUMBER; restart = 1'b1; end
        end
        MODE_STRING: begin
          if (ch == 8'h22) begin
            nres = 2'd1; fin.kind = TK_STRING; fin.len = rl_inc;
            mode_next = MODE_IDLE;
          end else if (ch == 8'h0a) begin
            nres = 2'd1; fin.kind = TK_ERR_STRING; mode_next = MODE_IDLE;
          end
        end
        MODE_CHAR_OPEN: begin
          if (ch == 8'h0a) begin
            nres = 2'd1; fin.kind = TK_ERR_CLIT; restart = 1'b1;
          end else begin
            mode_next = MODE_CHAR_BODY;
          end
        end
        MODE_CHAR_BODY: begin
          if (ch == 8'h27) begin
            nres = 2'd1; fin.kind = TK_CHAR; fin.len = rl_inc;
            mode_next = MODE_IDLE;
          end else begin
            nres = 2'd1; fin.kind = TK_ERR_BIG; restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
    end

    r0 = fin;
    // extend the current token when no token closed on a continuing mode
    if (!is_end && !restart && nres == 2'd0) begin
      hash_next = fnv_step(hash, ch);
      run_len_next = rl_inc;
    end
    if (nres != 2'd0) begin
      hash_next = FNV_BASIS;
      run_len_next = '0;
    end

    if (restart) begin
      mode_next = MODE_IDLE;
      if (is_punct || !(ws || ch == 8'h22 || ch == 8'h27 || alpha || digit)) begin
        if (nres == 2'd0) r0 = tk; else r1 = tk;
        nres = nres + 2'd1;
      end else if (!ws) begin
        if (ch == 8'h22)      mode_next = MODE_STRING;
        else if (ch == 8'h27) mode_next = MODE_CHAR_OPEN;
        else if (alpha)       mode_next = MODE_IDENT;
        else                  mode_next = MODE_NUMBER;
        st_off_next = cur_off; st_line_next = cur_line; st_col_next = cur_col;
        hash_next = fnv_step(FNV_BASIS, ch);
        run_len_next = POS_BITS'(1);
      end
    end

    if (at_eof) begin
      tk.kind = TK_EOF; tk.len = '0;
      if (nres == 2'd0) r0 = tk; else r1 = tk;
      nres = nres + 2'd1;
    end else begin
      cur_off_next = (cur_off == PMAX) ? PMAX : cur_off + 1'b1;
      if (ch == 8'h0a) begin
        cur_col_next  = COL_BITS'(1);
        cur_line_next = (cur_line == PMAX) ? PMAX : cur_line + 1'b1;
      end else begin
        csum = {1'b0, cur_col} + ((ch == 8'h09) ? (COL_BITS+1)'(tab_width)
                                                : (COL_BITS+1)'(1));
        cur_col_next = csum[COL_BITS] ? CMAX : csum[COL_BITS-1:0];
      end
    end

    if (nres == 2'd1) r0.lst = 1'b1;
    if (nres == 2'd2) r1.lst = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= TAB_RESET;
      mode <= MODE_IDLE; hash <= FNV_BASIS; run_len <= '0;
      st_off <= '0; st_line <= '0; st_col <= COL_BITS'(1);
      cur_off <= '0; cur_line <= '0; cur_col <= COL_BITS'(1);
    end else begin
      if (cfg_we) tab_width <= cfg_wdata;
      if (accept) begin
        mode <= mode_next; hash <= hash_next; run_len <= run_len_next;
        st_off <= st_off_next; st_line <= st_line_next; st_col <= st_col_next;
        cur_off <= cur_off_next; cur_line <= cur_line_next;
        cur_col <= cur_col_next;
      end
    end
  end

  // output queue: q0 is the head; new results append behind what remains
  always_ff @(posedge clk) begin
    logic [1:0] keep, add;
    keep = cnt - {1'b0, pop};
    add  = accept ? nres : 2'd0;
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= keep + add;
    end
    if (pop && cnt == 2'd2) q0 <= q1;
    if (keep == 2'd0) begin
      if (add != 2'd0) q0 <= r0;
      if (add == 2'd2) q1 <= r1;
    end else if (add != 2'd0) begin
      q1 <= r0;
    end
  end

endmodule

### hw/rtl/ctl_kw_match.sv
// Keyword lookup: compares hash and length against the keyword table.
module ctl_kw_match import ctl_pkg::*; #(
  parameter int POS_BITS     = POS_BITS_DEF,
  parameter int NUM_KEYWORDS = NUM_KEYWORDS_DEF
) (
  input  logic [63:0]         hash,
  input  logic [POS_BITS-1:0] length,
  output logic                hit,
  output logic [4:0]          index
);

  always_comb begin
    hit   = 1'b0;
    index = '0;
    for (int i = KW_TABLE_SIZE - 1; i >= 0; i--) begin
      if (i < NUM_KEYWORDS && kw_hash(i) == hash &&
          length == POS_BITS'(kw_len(i))) begin
        hit   = 1'b1;
        index = 5'(i);
      end
    end
  end

endmodule

### hw/rtl/ctl_checker.sv
// Port checker for the C token lexer, bound to the top level.
module ctl_checker import ctl_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       is_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] token_kind,
  input logic [4:0] keyword_index,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind))
    else $error("result dropped under stall");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(is_end))
    else $error("input item dropped while waiting");

  a_kw_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != TK_KEYWORD |-> keyword_index == 5'd0)
    else $error("keyword index on non-keyword");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_EOF |-> last)
    else $error("eof not last");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= TK_ERR_BIG)
    else $error("bad kind");

endmodule

bind c_token_lexer ctl_checker u_ctl_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .is_end(is_end), .out_valid(out_valid), .out_ready(out_ready),
  .token_kind(token_kind), .keyword_index(keyword_index), .last(last)
);

### bench/tb.sv
// Testbench for the streaming C token lexer: random and directed text, scoreboard check.
module tb import ctl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } char_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [4:0]  kw;
    logic [31:0] line;
    logic [15:0] col;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } token_t;

  localparam logic [63:0] FNV_PRIME = 64'h100000001b3;
  localparam logic [31:0] POS_SAT   = 32'hffffffff;
  localparam logic [15:0] COL_SAT   = 16'hffff;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = '0;
  logic        is_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  token_kind;
  logic [4:0]  keyword_index;
  logic [31:0] token_line;
  logic [15:0] token_col;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  c_token_lexer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch), .is_end(is_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .token_kind(token_kind), .keyword_index(keyword_index),
    .token_line(token_line), .token_col(token_col),
    .token_start(token_start), .token_length(token_length),
    .last(last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  char_item_t pending_chars[$];
  token_t     expected_tokens[$];
  int         error_count = 0;
  int         hold_off = 0;
  bit         out_stall_on = 1'b1;

  // lexer shadow state
  logic [3:0]  tab_w;
  lex_mode_t   mode;
  logic [63:0] hash;
  logic [31:0] run_len, st_off, st_line, cur_off, cur_line;
  logic [15:0] st_col, cur_col;
  token_t      step_out[$];

  function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? POS_SAT : s[31:0];
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = a + b;
    return s[16] ? COL_SAT : s[15:0];
  endfunction

  function automatic void shadow_reset();
    tab_w = TAB_RESET; mode = MODE_IDLE; hash = FNV_BASIS; run_len = 32'd0;
    st_off = 32'd0; st_line = 32'd0; st_col = 16'd1;
    cur_off = 32'd0; cur_line = 32'd0; cur_col = 16'd1;
  endfunction

  function automatic void push_tok(token_kind_t k, logic [4:0] kw, logic [31:0] ln,
                                   logic [15:0] cl, logic [31:0] so, logic [31:0] len);
    token_t t;
    t.kind = k; t.kw = kw; t.line = ln; t.col = cl; t.start = so; t.len = len;
    t.last = 1'b0;
    step_out.push_back(t);
  endfunction

  function automatic void move_pos(logic [7:0] c);
    cur_off = sat32(cur_off, 32'd1);
    if (c == 8'h0a) begin
      cur_col = 16'd1;
      cur_line = sat32(cur_line, 32'd1);
    end else if (c == 8'h09) begin
      cur_col = sat16(cur_col, {12'd0, tab_w});
    end else begin
      cur_col = sat16(cur_col, 16'd1);
    end
  endfunction

  function automatic void open_tok(lex_mode_t m);
    mode = m; st_off = cur_off; st_line = cur_line; st_col = cur_col;
    hash = FNV_BASIS; run_len = 32'd0;
  endfunction

  function automatic void grow(logic [7:0] c);
    hash = (hash ^ {56'd0, c}) * FNV_PRIME;
    run_len = sat32(run_len, 32'd1);
    move_pos(c);
  endfunction

  function automatic void close_tok(token_kind_t k, logic [4:0] kw);
    push_tok(k, kw, st_line, st_col, st_off, run_len);
    mode = MODE_IDLE; hash = FNV_BASIS; run_len = 32'd0;
  endfunction

  function automatic void close_word();
    for (int i = 0; i < KW_TABLE_SIZE; i++) begin
      if (kw_hash(i) == hash && run_len == {28'd0, kw_len(i)}) begin
        close_tok(TK_KEYWORD, i[4:0]);
        return;
      end
    end
    close_tok(TK_IDENT, 5'd0);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void between_tokens(logic [7:0] c);
    token_kind_t k;
    bit punct;
    punct = 1'b1;
    case (c)
      "(": k = TK_LPAREN;
      ")": k = TK_RPAREN;
      "{": k = TK_LBRACE;
      "}": k = TK_RBRACE;
      "=": k = TK_ASSIGN;
      "*": k = TK_STAR;
      ";": k = TK_SEMI;
      default: begin
        punct = 1'b0;
        k = TK_ERR_CHAR;
      end
    endcase
    if (punct) begin
      push_tok(k, 5'd0, cur_line, cur_col, cur_off, 32'd1);
      move_pos(c);
    end else if (c == 8'h22) begin
      open_tok(MODE_STRING); grow(c);
    end else if (c == 8'h27) begin
      open_tok(MODE_CHAR_OPEN); grow(c);
    end else if (c == " " || c == 8'h0a || c == 8'h09) begin
      move_pos(c);
    end else if (is_letter(c)) begin
      open_tok(MODE_IDENT); grow(c);
    end else if (is_num(c)) begin
      open_tok(MODE_NUMBER); grow(c);
    end else begin
      push_tok(TK_ERR_CHAR, 5'd0, cur_line, cur_col, cur_off, 32'd1);
      move_pos(c);
    end
  endfunction

  // predict the tokens one character item produces and queue them
  function automatic void lex_char(char_item_t it);
    logic [7:0] c;
    token_t t;
    c = it.ch;
    step_out.delete();
    if (it.is_end) begin
      case (mode)
        MODE_IDENT: close_word();
        MODE_NUMBER: close_tok(TK_NUMBER, 5'd0);
        MODE_STRING: close_tok(TK_ERR_STRING, 5'd0);
        MODE_CHAR_OPEN, MODE_CHAR_BODY: close_tok(TK_ERR_CLIT, 5'd0);
        default: ;
      endcase
      mode = MODE_IDLE;
      push_tok(TK_EOF, 5'd0, cur_line, cur_col, cur_off, 32'd0);
    end else begin
      case (mode)
        MODE_IDENT:
          if (is_letter(c) || is_num(c)) grow(c);
          else begin
            close_word(); between_tokens(c);
          end
        MODE_NUMBER:
          if (is_num(c)) grow(c);
          else begin
            close_tok(TK_NUMBER, 5'd0); between_tokens(c);
          end
        MODE_STRING:
          if (c == 8'h22) begin
            grow(c); close_tok(TK_STRING, 5'd0);
          end else if (c == 8'h0a) begin
            close_tok(TK_ERR_STRING, 5'd0); move_pos(c);
          end else grow(c);
        MODE_CHAR_OPEN:
          if (c == 8'h0a) begin
            close_tok(TK_ERR_CLIT, 5'd0); between_tokens(c);
          end else begin
            grow(c); mode = MODE_CHAR_BODY;
          end
        MODE_CHAR_BODY:
          if (c == 8'h27) begin
            grow(c); close_tok(TK_CHAR, 5'd0);
          end else begin
            close_tok(TK_ERR_BIG, 5'd0); between_tokens(c);
          end
        default: begin
          mode = MODE_IDLE; between_tokens(c);
        end
      endcase
    end
    for (int i = 0; i < step_out.size(); i++) begin
      t = step_out[i];
      t.last = (i == step_out.size() - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // sampled acceptance flag, updated at the rising edge
  bit in_ready_s = 1'b0;
  always @(posedge clk) in_ready_s <= in_valid && in_ready;

  // driver: hold the item until accepted, then idle for a gap or advance
  int  in_gap = 0;
  char_item_t cur_item;
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_ready_s)) begin
      if (in_valid) in_gap = gap_len();
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        cur_item = pending_chars.pop_front();
        lex_char(cur_item);
        ch <= cur_item.ch;
        is_end <= cur_item.is_end;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall control
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else if (!out_stall_on) out_ready <= 1'b1;
    else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = gap_len();
    end
  end

  // monitor
  token_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("extra token kind", 64'(token_kind), 64'd0);
      end else begin
        want = expected_tokens.pop_front();
        if (token_kind !== want.kind)
          report_mismatch("kind", 64'(token_kind), 64'(want.kind));
        if (keyword_index !== want.kw)
          report_mismatch("keyword", 64'(keyword_index), 64'(want.kw));
        if (token_line !== want.line)
          report_mismatch("line", 64'(token_line), 64'(want.line));
        if (token_col !== want.col)
          report_mismatch("col", 64'(token_col), 64'(want.col));
        if (token_start !== want.start)
          report_mismatch("start", 64'(token_start), 64'(want.start));
        if (token_length !== want.len)
          report_mismatch("length", 64'(token_length), 64'(want.len));
        if (last !== want.last)
          report_mismatch("last", 64'(last), 64'(want.last));
      end
    end
  end

  function automatic void queue_text(string s);
    char_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i]; it.is_end = 1'b0;
      pending_chars.push_back(it);
    end
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic e);
    char_item_t it;
    it.ch = b; it.is_end = e;
    pending_chars.push_back(it);
  endfunction

  function automatic void queue_noise();
    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 30) == 0);
  endfunction

  // a fragment with random content, mostly well-formed but at times an open literal or noise
  function automatic void queue_fragment();
    string words[10] = '{"int", "return", "while", "short", "typedef", "x1", "foo",
                         "unsigned", "default", "char"};
    string punct = "(){}=*;";
    int n;
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0, 1: queue_text(words[$urandom_range(0, 9)]);
      2: begin
        n = $urandom_range(1, 5);
        repeat (n) queue_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
      3: begin
        queue_byte(8'h22, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) begin
          b = 8'($urandom_range(32, 126));
          queue_byte(b == 8'h22 ? "a" : b, 1'b0);
        end
        if ($urandom_range(0, 5) != 0) queue_byte(8'h22, 1'b0);
      end
      4: begin
        queue_byte(8'h27, 1'b0);
        queue_byte(8'($urandom_range(32, 126)), 1'b0);
        if ($urandom_range(0, 4) != 0) queue_byte(8'h27, 1'b0);
      end
      5: queue_byte(punct[$urandom_range(0, 6)], 1'b0);
      6: queue_noise();
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: queue_byte(" ", 1'b0);
      1: queue_byte(8'h09, 1'b0);
      2: queue_byte(8'h0a, 1'b0);
      default: ;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_chars.size() > 0 || in_valid || expected_tokens.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_tab(logic [3:0] w);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    tab_w = w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int target;
    logic [3:0] tabs[4];
    tabs = '{4'd0, 4'd15, 4'd1, 4'd8};
    shadow_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: punctuators, keywords, literals, every error kind, extremes
    queue_text("(){}=*;\tint short char default while x9 0123 \"ab\" 'c' ");
    queue_text("\"no end\n'\n'ab @"); queue_byte(8'h0d, 1'b0); queue_byte(8'hff, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'h00, 1'b0);
    queue_text("abc"); queue_byte(8'h00, 1'b1);
    queue_text("\"open"); queue_byte(8'h00, 1'b1);
    queue_text("'x"); queue_byte(8'h00, 1'b1);
    queue_byte(8'h7f, 1'b1);
    wait_drained();

    // tab width extremes between phases
    foreach (tabs[i]) begin
      write_tab(tabs[i]);
      target = 200;
      while (pending_chars.size() < target) begin
        if ($urandom_range(0, 9) < 8) queue_fragment();
        else queue_noise();
      end
      if (i == 1) begin
        hold_off = 200;
      end
      if (i == 2) out_stall_on = 1'b0;
      if (i == 3) out_stall_on = 1'b1;
      wait_drained();
    end

    // final random phase with a mid-run pause until drained
    write_tab(4'd3);
    repeat (60) queue_fragment();
    wait_drained();
    repeat (60) queue_fragment();
    queue_byte(8'h00, 1'b1);
    wait_drained();
    if (error_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end
endmodule
